FILE: sv/ckas_pkg.sv
// shared types and constants for the can keepalive supervisor
package ckas_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned ID_W   = 29;

    localparam logic [ID_W-1:0]  KA_ID            = 29'h305;
    localparam logic [CFG_W-1:0] DEFAULT_INTERVAL = 16'd1000;

    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] RETRY_RESET    = 16'd0;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 16'd5000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_INTERVAL = 2'd0,
        REG_RETRY    = 2'd1,
        REG_TIMEOUT  = 2'd2
    } cfg_idx_t;

endpackage

FILE: sv/can_keepalive_supervisor_core.sv
// top level of the can keepalive supervisor: request register, link logic, result register
//
// channel   | group      | signals                        | content
// ----------+------------+--------------------------------+------------------------------------
// request   | s_axis_*   | tvalid tready tdata[63:0] tuser| cmd in tuser; time, frame in tdata
// result    | m_axis_*   | tvalid tready tdata[7:0]       | attempts, link ok, lost, seen
// config    | cfg_*      | we index[1:0] data[15:0]       | interval, retry, timeout
//
// one request per cycle sustained while results are taken; an accepted request is held in
// stage one, and its result is registered into stage two when stage two is free
// stage one holds the accepted request, stage two holds the result, state updates as a
// request moves from stage one to stage two
// a stalled result holds stage two; stage one still takes one more request behind it
// asynchronous active-low reset clears valids, link state and config to their defaults
module can_keepalive_supervisor_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // now_ms[31:0], frame_id[60:32], frame_extended[61],
                                        // frame_remote[62], tx_accept[63]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // send_attempts[1:0], link_ok[2], link_lost[3],
                                        // keepalive_seen[4], zero fill[7:5]

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned TW = ckas_pkg::TIME_W;
    localparam int unsigned CW = ckas_pkg::CFG_W;
    localparam int unsigned IW = ckas_pkg::ID_W;

    // configuration registers
    logic [CW-1:0] interval_reg;
    logic [CW-1:0] retry_reg;
    logic [CW-1:0] timeout_reg;

    // link state
    logic          running_reg;
    logic          running_next;
    logic          alive_reg;
    logic          alive_next;
    logic [TW-1:0] last_send_reg;
    logic [TW-1:0] last_send_next;
    logic [TW-1:0] last_rx_reg;
    logic [TW-1:0] last_rx_next;

    // stage one: accepted request
    logic              in_valid_reg;
    ckas_pkg::cmd_t    in_cmd_reg;
    logic [TW-1:0]     in_now_reg;
    logic [IW-1:0]     in_id_reg;
    logic              in_ext_reg;
    logic              in_rtr_reg;
    logic              in_accept_reg;

    // stage two: result
    logic              out_valid_reg;
    logic [1:0]        out_attempts_reg;
    logic              out_ok_reg;
    logic              out_lost_reg;
    logic              out_seen_reg;

    logic              advance;

    // computed result
    logic [1:0]        attempts;
    logic              lost;
    logic              seen;

    // stage two frees when empty or when the result is taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // config writes, out of range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= ckas_pkg::INTERVAL_RESET;
            retry_reg    <= ckas_pkg::RETRY_RESET;
            timeout_reg  <= ckas_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ckas_pkg::REG_INTERVAL: interval_reg <= cfg_data;
                ckas_pkg::REG_RETRY:    retry_reg    <= cfg_data;
                ckas_pkg::REG_TIMEOUT:  timeout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg    <= ckas_pkg::cmd_t'(s_axis_tuser);
            in_now_reg    <= s_axis_tdata[31:0];
            in_id_reg     <= s_axis_tdata[60:32];
            in_ext_reg    <= s_axis_tdata[61];
            in_rtr_reg    <= s_axis_tdata[62];
            in_accept_reg <= s_axis_tdata[63];
        end
    end

    // link logic for the request in stage one
    always_comb
    begin
        logic [CW-1:0] eff_iv;
        logic [CW-1:0] tick_iv;
        logic [TW-1:0] since_send;
        logic [TW-1:0] since_rx;
        logic          send_a;
        logic          send_b;

        eff_iv     = (interval_reg == '0) ? ckas_pkg::DEFAULT_INTERVAL : interval_reg;
        tick_iv    = (!alive_reg && retry_reg != '0 && retry_reg < eff_iv) ? retry_reg : eff_iv;
        since_send = in_now_reg - last_send_reg;
        since_rx   = in_now_reg - last_rx_reg;
        send_a     = 1'b0;
        send_b     = 1'b0;
        lost       = 1'b0;
        seen       = 1'b0;

        running_next   = running_reg;
        alive_next     = alive_reg;
        last_send_next = last_send_reg;
        last_rx_next   = last_rx_reg;

        unique case (in_cmd_reg)
            ckas_pkg::CMD_START:
            begin
                if (!running_reg)
                begin
                    running_next   = 1'b1;
                    alive_next     = 1'b0;
                    last_rx_next   = in_now_reg;
                    // backdate by one interval, clamp at zero
                    last_send_next = (in_now_reg >= {{(TW-CW){1'b0}}, eff_iv}) ?
                                     in_now_reg - {{(TW-CW){1'b0}}, eff_iv} : '0;
                end
                send_a = 1'b1;
            end
            ckas_pkg::CMD_FRAME:
            begin
                if (running_reg && !in_ext_reg && in_id_reg == ckas_pkg::KA_ID)
                begin
                    seen         = 1'b1;
                    last_rx_next = in_now_reg;
                    alive_next   = 1'b1;
                    send_a       = in_rtr_reg;
                end
            end
            ckas_pkg::CMD_TICK:
            begin
                if (running_reg)
                begin
                    send_a = (since_send >= {{(TW-CW){1'b0}}, tick_iv});
                    if (alive_reg && timeout_reg != '0 &&
                        since_rx > {{(TW-CW){1'b0}}, timeout_reg})
                    begin
                        alive_next = 1'b0;
                        lost       = 1'b1;
                        send_b     = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // every send stamps the send time once the transmitter takes it
        if ((send_a || send_b) && in_accept_reg)
        begin
            last_send_next = in_now_reg;
        end
        attempts = {1'b0, send_a} + {1'b0, send_b};
    end

    // state update as the request moves into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            alive_reg     <= 1'b0;
            last_send_reg <= '0;
            last_rx_reg   <= '0;
        end
        else if (advance)
        begin
            running_reg   <= running_next;
            alive_reg     <= alive_next;
            last_send_reg <= last_send_next;
            last_rx_reg   <= last_rx_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_attempts_reg <= attempts;
            out_ok_reg       <= alive_next;
            out_lost_reg     <= lost;
            out_seen_reg     <= seen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_seen_reg, out_lost_reg, out_ok_reg, out_attempts_reg};

`ifndef SYNTHESIS
    // a lost link always drops link ok and sends a keepalive
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_lost_reg) |-> (!out_ok_reg && out_attempts_reg != 2'd0))
        else $error("link lost without drop or send");

    // a matched keepalive frame leaves the link ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_seen_reg) |-> out_ok_reg)
        else $error("keepalive seen but link not ok");

    // once started the supervisor stays running until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |=> running_reg)
        else $error("running dropped without reset");

    // state only changes when a request moves to the result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(alive_reg) && $stable(last_send_reg) && $stable(last_rx_reg)))
        else $error("link state changed without a request");
`endif

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the can keepalive supervisor core
`timescale 1ns / 1ps

module tb_top;

    // cmd value the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 4000;

    // one request as the sender sees it
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] now;
        logic [28:0] fid;
        logic        ext;
        logic        rtr;
        logic        acc;
    } ka_request_t;

    // one result as the predictor produces it
    typedef struct {
        logic [1:0] attempts;
        logic       ok;
        logic       lost;
        logic       seen;
    } ka_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // now_ms[31:0], frame_id[60:32], frame_extended[61],
                                       // frame_remote[62], tx_accept[63]
    logic [1:0]  s_axis_tuser = '0;    // cmd[1:0]

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // send_attempts[1:0], link_ok[2], link_lost[3],
                                       // keepalive_seen[4], zero fill[7:5]

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor copy of the register file
    logic [15:0] interval_cfg = ckas_pkg::INTERVAL_RESET;
    logic [15:0] retry_cfg    = ckas_pkg::RETRY_RESET;
    logic [15:0] timeout_cfg  = ckas_pkg::TIMEOUT_RESET;

    // predictor copy of the link state
    logic        sup_running  = 1'b0;
    logic        sup_alive    = 1'b0;
    logic [31:0] sup_last_tx  = '0;
    logic [31:0] sup_last_rx  = '0;

    ka_status_t  pending_status[$];    // predicted results in request order
    int          mismatches = 0;
    int          results_seen = 0;
    bit          idle_on = 1'b1;       // random gaps on both sides
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] stim_now = '0;        // running millisecond clock for random requests

    can_keepalive_supervisor_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // one keepalive attempt; the send time only moves when the transmitter takes it
    function automatic void record_send(input logic [31:0] now, input logic acc,
                                        inout logic [1:0] n);
        n = n + 2'd1;
        if (acc)
            sup_last_tx = now;
    endfunction

    function automatic ka_status_t predict_link_status(input ka_request_t rq);
        ka_status_t  st;
        logic [31:0] period;
        logic [31:0] since_tx;
        logic [31:0] since_rx;
        st = '{attempts: 2'd0, ok: 1'b0, lost: 1'b0, seen: 1'b0};
        // zero interval falls back to the default period
        period = (interval_cfg == '0) ? 32'(ckas_pkg::DEFAULT_INTERVAL) : 32'(interval_cfg);
        case (rq.cmd)
            ckas_pkg::CMD_START:
            begin
                // first start arms the block and backdates the send time by one period
                if (!sup_running)
                begin
                    sup_running = 1'b1;
                    sup_alive   = 1'b0;
                    sup_last_rx = rq.now;
                    sup_last_tx = (rq.now >= period) ? rq.now - period : '0;
                end
                record_send(rq.now, rq.acc, st.attempts);
            end
            ckas_pkg::CMD_FRAME:
            begin
                // only a standard-id keepalive frame counts
                if (sup_running && !rq.ext && rq.fid == ckas_pkg::KA_ID)
                begin
                    st.seen     = 1'b1;
                    sup_last_rx = rq.now;
                    sup_alive   = 1'b1;
                    if (rq.rtr)
                        record_send(rq.now, rq.acc, st.attempts);
                end
            end
            ckas_pkg::CMD_TICK:
            begin
                if (sup_running)
                begin
                    // faster retry period only while down, and only if shorter
                    if (!sup_alive && retry_cfg != '0 && 32'(retry_cfg) < period)
                        period = 32'(retry_cfg);
                    since_tx = rq.now - sup_last_tx;
                    if (since_tx >= period)
                        record_send(rq.now, rq.acc, st.attempts);
                    since_rx = rq.now - sup_last_rx;
                    if (sup_alive && timeout_cfg != '0 && since_rx > 32'(timeout_cfg))
                    begin
                        sup_alive = 1'b0;
                        st.lost   = 1'b1;
                        record_send(rq.now, rq.acc, st.attempts);
                    end
                end
            end
            default:
            begin
                // unused command: no effect on state
            end
        endcase
        st.ok = sup_alive;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // drive one request at a falling edge, hold it until accepted, then predict
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] now,
                                input logic [28:0] fid, input logic ext,
                                input logic rtr, input logic acc);
        ka_request_t rq;
        rq = '{cmd: cmd, now: now, fid: fid, ext: ext, rtr: rtr, acc: acc};
        // random gap before the request
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {acc, rtr, ext, fid, now};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_status.push_back(predict_link_status(rq));
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        // pipeline is two deep; give a spurious extra result time to show up
        repeat (4) @(posedge clk);
    endtask

    // register write while the block is idle; predictor copy follows
    task automatic write_reg(input ckas_pkg::cfg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ckas_pkg::REG_INTERVAL: interval_cfg = value;
            ckas_pkg::REG_RETRY:    retry_cfg    = value;
            ckas_pkg::REG_TIMEOUT:  timeout_cfg  = value;
            default:      ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    endtask

    // random backpressure bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        ka_status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_status.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_status.pop_front();
                if (m_axis_tdata[1:0] !== want.attempts)
                    report_mismatch($sformatf("send_attempts %0d, predicted %0d",
                                              m_axis_tdata[1:0], want.attempts));
                if (m_axis_tdata[2] !== want.ok)
                    report_mismatch($sformatf("link_ok %b, predicted %b",
                                              m_axis_tdata[2], want.ok));
                if (m_axis_tdata[3] !== want.lost)
                    report_mismatch($sformatf("link_lost %b, predicted %b",
                                              m_axis_tdata[3], want.lost));
                if (m_axis_tdata[4] !== want.seen)
                    report_mismatch($sformatf("keepalive_seen %b, predicted %b",
                                              m_axis_tdata[4], want.seen));
            end
        end
    end

    // hang detector: no handshake on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // before the first start every command is ignored
    task automatic test_idle_before_start();
        send_request(ckas_pkg::CMD_TICK, 32'd100, 29'd0, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_FRAME, 32'd100, ckas_pkg::KA_ID, 1'b0, 1'b1, 1'b1);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 29'h1FFF_FFFF, 1'b1, 1'b1, 1'b1);
    endtask

    // start clamps the backdated send time, then the interval boundary
    task automatic test_start_and_interval();
        send_request(ckas_pkg::CMD_START, 32'd500, 29'd0, 1'b0, 1'b0, 1'b0);
        send_request(ckas_pkg::CMD_START, 32'd600, 29'd0, 1'b0, 1'b0, 1'b1); // already running
        send_request(ckas_pkg::CMD_TICK, 32'd1599, 29'd0, 1'b0, 1'b0, 1'b1); // one short
        send_request(ckas_pkg::CMD_TICK, 32'd1600, 29'd0, 1'b0, 1'b0, 1'b1); // exactly due
        send_request(ckas_pkg::CMD_TICK, 32'd2600, 29'd0, 1'b0, 1'b0, 1'b0); // due, not taken
        send_request(ckas_pkg::CMD_TICK, 32'd2601, 29'd0, 1'b0, 1'b0, 1'b1); // still due
    endtask

    // identifier matching and remote requests
    task automatic test_frame_matching();
        // extended id
        send_request(ckas_pkg::CMD_FRAME, 32'd2700, ckas_pkg::KA_ID, 1'b1, 1'b1, 1'b1);
        // near miss
        send_request(ckas_pkg::CMD_FRAME, 32'd2710, ckas_pkg::KA_ID ^ 29'd1, 1'b0, 1'b1, 1'b1);
        send_request(ckas_pkg::CMD_FRAME, 32'd2720, 29'h1FFF_FFFF, 1'b0, 1'b1, 1'b1);
        send_request(ckas_pkg::CMD_FRAME, 32'd2800, ckas_pkg::KA_ID, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_FRAME, 32'd2900, ckas_pkg::KA_ID, 1'b0, 1'b1, 1'b0);
        send_request(ckas_pkg::CMD_FRAME, 32'd3000, ckas_pkg::KA_ID, 1'b0, 1'b1, 1'b1);
    endtask

    // silence right at and just past the timeout, double send, time wrap
    task automatic test_timeout_and_wrap();
        send_request(ckas_pkg::CMD_TICK, 32'd8000, 29'd0, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_TICK, 32'd8001, 29'd0, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_FRAME, 32'd8100, ckas_pkg::KA_ID, 1'b0, 1'b0, 1'b1);
        // interval and loss
        send_request(ckas_pkg::CMD_TICK, 32'd13101, 29'd0, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_FRAME, 32'hFFFF_FF00, ckas_pkg::KA_ID, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_TICK, 32'h0000_0100, 29'd0, 1'b0, 1'b0, 1'b0);
    endtask

    // shorter retry period kicks in once the link is down
    task automatic test_retry_period();
        logic [31:0] t0;
        t0 = 32'h0001_0000;
        drain_results();
        write_reg(ckas_pkg::REG_RETRY, 16'd200);
        write_reg(ckas_pkg::REG_TIMEOUT, 16'd100);
        send_request(ckas_pkg::CMD_FRAME, t0, ckas_pkg::KA_ID, 1'b0, 1'b1, 1'b1);
        send_request(ckas_pkg::CMD_TICK, t0 + 32'd250, 29'd0, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_TICK, t0 + 32'd449, 29'd0, 1'b0, 1'b0, 1'b1);
        send_request(ckas_pkg::CMD_TICK, t0 + 32'd450, 29'd0, 1'b0, 1'b0, 1'b1);
    endtask

    // one register setting, then a stream of mostly well-formed traffic with
    // quiet spells so the timeout actually fires
    task automatic run_random_phase(input logic [15:0] iv, input logic [15:0] rt,
                                    input logic [15:0] tmo, input int count,
                                    input bit with_idle);
        int          span;
        int          quiet;
        int          pick;
        logic [1:0]  cmd;
        logic [28:0] fid;
        logic        ext;
        logic        rtr;
        drain_results();
        write_reg(ckas_pkg::REG_INTERVAL, iv);
        write_reg(ckas_pkg::REG_RETRY, rt);
        write_reg(ckas_pkg::REG_TIMEOUT, tmo);
        idle_on = with_idle;
        span = (iv == '0) ? int'(ckas_pkg::DEFAULT_INTERVAL) : int'(iv);
        if (int'(tmo) > span)
            span = int'(tmo);
        stim_now = $urandom();
        quiet = 0;
        repeat (count)
        begin
            // time step: mostly small, sometimes past every period, rarely anywhere
            pick = $urandom_range(0, 99);
            if (pick < 3)
                stim_now = $urandom();
            else if (pick < 15)
                stim_now += $urandom_range(0, 2 * span + 2);
            else
                stim_now += $urandom_range(0, span / 4 + 1);
            if (quiet == 0 && $urandom_range(0, 19) == 0)
                quiet = $urandom_range(8, 30);
            fid = 29'($urandom());
            ext = 1'($urandom_range(0, 1));
            rtr = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                cmd = CMD_UNUSED;
            else if (pick < 8)
                cmd = ckas_pkg::CMD_START;
            else if (pick < 42)
            begin
                cmd = ckas_pkg::CMD_FRAME;
                if (quiet != 0 || $urandom_range(0, 4) == 0)
                begin
                    // noise frames: extended keepalive id, a one-bit near miss or a random id
                    case ($urandom_range(0, 2))
                        0: fid = ckas_pkg::KA_ID;
                        1: fid = ckas_pkg::KA_ID ^ (29'd1 << $urandom_range(0, 28));
                        default: ;
                    endcase
                    if (fid == ckas_pkg::KA_ID)
                        ext = 1'b1;
                end
                else
                begin
                    fid = ckas_pkg::KA_ID;
                    ext = 1'b0;
                end
            end
            else
                cmd = ckas_pkg::CMD_TICK;
            if (quiet != 0)
                quiet--;
            send_request(cmd, stim_now, fid, ext, rtr, $urandom_range(0, 3) != 0);
        end
    endtask

    // register extremes first, then ordinary values, last phase without gaps
    task automatic test_random_phases();
        run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 136, 1'b1);
        run_random_phase(16'd0, 16'd0, 16'd0, 136, 1'b1);
        run_random_phase(16'd300, 16'd50, 16'd700, 136, 1'b1);
        run_random_phase(16'd100, 16'd400, 16'd1, 136, 1'b1);
        run_random_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(0, 500)),
                         16'($urandom_range(0, 3000)), 136, 1'b0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_before_start();
        test_start_and_interval();
        test_frame_matching();
        test_timeout_and_wrap();
        test_retry_period();
        test_random_phases();
        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
sv/ckas_pkg.sv
sv/can_keepalive_supervisor_core.sv
tb/tb_top.sv
